// ----- rtl/fpr_pkg.sv -----
// shared constants and types for the fifo page replacement block
`default_nettype none

package fpr_pkg;

   // page table geometry
   localparam int MAX_PAGES   = 256;
   localparam int PAGE_W      = $clog2(MAX_PAGES);
   localparam int MAX_FRAMES  = 64;
   localparam int FRAME_W     = 7;
   localparam int FRAME_ROWS  = 1 << FRAME_W;

   // configuration register widths
   localparam int PAGES_CFG_W  = 9;
   localparam int FRAMES_CFG_W = FRAME_W;
   localparam int PERIOD_W     = 16;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_IDX_W    = 2;

   // result widths
   localparam int TOTAL_W = 32;

   // victim search splits a frame row into groups of pages
   localparam int GROUP_W     = 16;
   localparam int NUM_GROUPS  = MAX_PAGES / GROUP_W;
   localparam int GROUP_IDX_W = $clog2(NUM_GROUPS);
   localparam int BIT_IDX_W   = $clog2(GROUP_W);

   // pointer modulo unit
   localparam int DIV_W     = FRAME_W + 1;
   localparam int DIV_CNT_W = $clog2(DIV_W);

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PAGES_IN_USE  = 2'd0,
      REG_FRAMES_IN_USE = 2'd1,
      REG_CLEAR_PERIOD  = 2'd2
   } csr_index_type;

   // one page table entry
   typedef struct packed {
      logic               dirty;
      logic               last_write;
      logic [FRAME_W-1:0] frame;
   } page_entry_type;

   localparam int PAGE_ENTRY_W = $bits(page_entry_type);

endpackage

`default_nettype wire

// ----- rtl/fpr_req_if.sv -----
// access request channel
`default_nettype none

interface fpr_req_if;
   logic                      valid;
   logic                      ready;
   logic [fpr_pkg::PAGE_W-1:0] page_number;
   logic                      is_write;

   modport source (output valid, output page_number, output is_write, input ready);
   modport sink (input valid, input page_number, input is_write, output ready);
endinterface

`default_nettype wire

// ----- rtl/fpr_rsp_if.sv -----
// access result channel
`default_nettype none

interface fpr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        fault;
   logic [fpr_pkg::FRAME_W-1:0] frame;
   logic                        evicted;
   logic [fpr_pkg::PAGE_W-1:0]  evicted_page;
   logic                        bad_access;
   logic [fpr_pkg::TOTAL_W-1:0] fault_total;

   modport source (output valid, output fault, output frame, output evicted,
                   output evicted_page, output bad_access, output fault_total,
                   input ready);
   modport sink (input valid, input fault, input frame, input evicted,
                 input evicted_page, input bad_access, input fault_total,
                 output ready);
endinterface

`default_nettype wire

// ----- rtl/fpr_csr_if.sv -----
// configuration write channel
`default_nettype none

interface fpr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [fpr_pkg::CSR_IDX_W-1:0]  index;
   logic [fpr_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/fpr_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module fpr_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/fifo_page_replacement_top.sv -----
// fifo page replacement: page table, frame rows and fifo victim selection
//
//   channel   dir   handshake      word
//   req_ch    in    valid/ready    page_number, is_write
//   rsp_ch    out   valid/ready    fault, frame, evicted, evicted_page, bad_access, fault_total
//   csr_ch    in    valid/ready    index, data (always ready)
//
// one access at a time; a hit takes the page table read, a miss also the frame row read, and a miss
// with no free frame the three-step victim search over the frame row; an out-of-range page skips
// both reads.
// a pointer that passes a lowered frame count is reduced in the modulo unit.
// after reset every frame row is cleared, with req_ch not ready.
// a waiting result holds in the output register while the next access is taken.
`default_nettype none

module fifo_page_replacement_top (
   input  logic      clock,
   input  logic      reset,
   fpr_req_if.sink   req_ch,
   fpr_rsp_if.source rsp_ch,
   fpr_csr_if.sink   csr_ch
);

   typedef enum logic [9:0] {
      ST_CLEAR        = 10'b0000000001,
      ST_IDLE         = 10'b0000000010,
      ST_LOOK         = 10'b0000000100,
      ST_SCAN_LOAD    = 10'b0000001000,
      ST_SCAN_GROUP   = 10'b0000010000,
      ST_SCAN_BIT     = 10'b0000100000,
      ST_WRITE_MAP    = 10'b0001000000,
      ST_WRITE_VICTIM = 10'b0010000000,
      ST_NEXT_PTR     = 10'b0100000000,
      ST_DONE         = 10'b1000000000
   } state_type;

   // lowest set bit of a group
   function automatic logic [fpr_pkg::BIT_IDX_W-1:0] lowest_set(
      input logic [fpr_pkg::GROUP_W-1:0] bits
   );
      logic [fpr_pkg::BIT_IDX_W-1:0] idx;
      idx = '0;
      for (int i = fpr_pkg::GROUP_W - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = fpr_pkg::BIT_IDX_W'(i);
         end
      end
      return idx;
   endfunction

   // frame count clamped to 1..MAX_FRAMES
   function automatic logic [fpr_pkg::FRAME_W-1:0] eff_frames(
      input logic [fpr_pkg::FRAME_W-1:0] f
   );
      logic [fpr_pkg::FRAME_W-1:0] r;
      r = f;
      if (f == '0) begin
         r = fpr_pkg::FRAME_W'(1);
      end else if (f > fpr_pkg::FRAME_W'(fpr_pkg::MAX_FRAMES)) begin
         r = fpr_pkg::FRAME_W'(fpr_pkg::MAX_FRAMES);
      end
      return r;
   endfunction

   // control state
   state_type                          state_ff, state_in;
   logic [fpr_pkg::FRAME_W-1:0]        clr_addr_ff, clr_addr_in;
   logic [fpr_pkg::PAGES_CFG_W-1:0]    pages_cfg_ff, pages_cfg_in;
   logic [fpr_pkg::FRAMES_CFG_W-1:0]   frames_cfg_ff, frames_cfg_in;
   logic [fpr_pkg::PERIOD_W-1:0]       period_ff, period_in;
   logic [fpr_pkg::FRAME_W-1:0]        free_ff, free_in;
   logic [fpr_pkg::FRAME_W-1:0]        next_ff, next_in;
   logic [fpr_pkg::FRAME_W-1:0]        oldest_ff, oldest_in;
   logic [fpr_pkg::PERIOD_W-1:0]       acc_ff, acc_in;
   logic [fpr_pkg::TOTAL_W-1:0]        faults_ff, faults_in;
   logic [fpr_pkg::MAX_PAGES-1:0]      mapped_ff, mapped_in;
   logic [fpr_pkg::MAX_PAGES-1:0]      refd_ff, refd_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // per access working registers
   logic [fpr_pkg::PAGE_W-1:0]         page_ff, page_in;
   logic                               wr_ff, wr_in;
   logic                               bad_ff, bad_in;
   logic                               fault_ff, fault_in;
   logic [fpr_pkg::FRAME_W-1:0]        frame_ff, frame_in;
   logic                               evict_ff, evict_in;
   logic [fpr_pkg::PAGE_W-1:0]         victim_ff, victim_in;
   logic                               clear_ref_ff, clear_ref_in;
   logic                               use_free_ff, use_free_in;
   logic                               need_div_ff, need_div_in;
   logic [fpr_pkg::MAX_PAGES-1:0]      row_ff, row_in;
   logic [fpr_pkg::NUM_GROUPS-1:0]     grp_any_ff, grp_any_in;
   logic [fpr_pkg::GROUP_IDX_W-1:0]    grp_ff, grp_in;
   logic [fpr_pkg::DIV_W-1:0]          mod_rem_ff, mod_rem_in;
   logic [fpr_pkg::DIV_W-1:0]          mod_dvd_ff, mod_dvd_in;
   logic [fpr_pkg::DIV_CNT_W-1:0]      mod_cnt_ff, mod_cnt_in;

   // result register
   logic                               rsp_fault_ff, rsp_fault_in;
   logic [fpr_pkg::FRAME_W-1:0]        rsp_frame_ff, rsp_frame_in;
   logic                               rsp_evicted_ff, rsp_evicted_in;
   logic [fpr_pkg::PAGE_W-1:0]         rsp_victim_ff, rsp_victim_in;
   logic                               rsp_bad_ff, rsp_bad_in;
   logic [fpr_pkg::TOTAL_W-1:0]        rsp_total_ff, rsp_total_in;

   // memory ports
   logic                               pg_wr_en, pg_rd_en;
   logic [fpr_pkg::PAGE_W-1:0]         pg_wr_addr, pg_rd_addr;
   logic [fpr_pkg::PAGE_ENTRY_W-1:0]   pg_wr_data, pg_rd_data;
   fpr_pkg::page_entry_type            pg_entry, pg_new;
   logic                               bm_wr_en, bm_rd_en;
   logic [fpr_pkg::FRAME_W-1:0]        bm_wr_addr, bm_rd_addr;
   logic [fpr_pkg::MAX_PAGES-1:0]      bm_wr_data, bm_rd_data;

   // shared combinational terms
   logic [fpr_pkg::FRAME_W-1:0]        eff;
   logic [fpr_pkg::PERIOD_W-1:0]       period_eff;
   logic [fpr_pkg::PERIOD_W:0]         acc_inc;
   logic                               clear_now;
   logic                               req_bad;
   logic [fpr_pkg::FRAME_W-1:0]        frame_sel;
   logic [fpr_pkg::FRAME_W-1:0]        ptr_cur;
   logic [fpr_pkg::DIV_W-1:0]          ptr_inc;
   logic [fpr_pkg::DIV_W-1:0]          div_try;
   logic [fpr_pkg::GROUP_W-1:0]        grp_bits;
   logic [fpr_pkg::MAX_PAGES-1:0]      row_new;
   logic                               rsp_free;

   // page table: frame, dirty and last access kind per page
   fpr_ram #(
      .WIDTH (fpr_pkg::PAGE_ENTRY_W),
      .DEPTH (fpr_pkg::MAX_PAGES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (pg_wr_en),
      .wr_addr (pg_wr_addr),
      .wr_data (pg_wr_data),
      .rd_en   (pg_rd_en),
      .rd_addr (pg_rd_addr),
      .rd_data (pg_rd_data)
   );

   // frame rows: one bit per page that is mapped to the frame
   fpr_ram #(
      .WIDTH (fpr_pkg::MAX_PAGES),
      .DEPTH (fpr_pkg::FRAME_ROWS)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (bm_wr_en),
      .wr_addr (bm_wr_addr),
      .wr_data (bm_wr_data),
      .rd_en   (bm_rd_en),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data)
   );

   // handshake outputs
   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.fault        = rsp_fault_ff;
   assign rsp_ch.frame        = rsp_frame_ff;
   assign rsp_ch.evicted      = rsp_evicted_ff;
   assign rsp_ch.evicted_page = rsp_victim_ff;
   assign rsp_ch.bad_access   = rsp_bad_ff;
   assign rsp_ch.fault_total  = rsp_total_ff;

   // effective configuration and access period
   assign eff        = eff_frames(frames_cfg_ff);
   assign period_eff = (period_ff == '0) ? fpr_pkg::PERIOD_W'(1) : period_ff;
   assign acc_inc    = {1'b0, acc_ff} + (fpr_pkg::PERIOD_W + 1)'(1);
   assign clear_now  = (acc_inc >= {1'b0, period_eff});
   assign req_bad    = ({1'b0, req_ch.page_number} >= pages_cfg_ff);
   assign frame_sel  = (free_ff != '0) ? next_ff : oldest_ff;
   assign ptr_cur    = use_free_ff ? next_ff : oldest_ff;
   assign ptr_inc    = {1'b0, ptr_cur} + fpr_pkg::DIV_W'(1);
   assign div_try    = {mod_rem_ff[fpr_pkg::DIV_W-2:0], mod_dvd_ff[fpr_pkg::DIV_W-1]};
   assign grp_bits   = row_ff[grp_ff * fpr_pkg::GROUP_W +: fpr_pkg::GROUP_W];
   assign pg_entry   = fpr_pkg::page_entry_type'(pg_rd_data);
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;

   // new frame row: victim out, accessed page in
   always_comb begin
      row_new = row_ff;
      if (evict_ff) begin
         row_new[victim_ff] = 1'b0;
      end
      row_new[page_ff] = 1'b1;
   end

   // access sequencer
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      pages_cfg_in  = pages_cfg_ff;
      frames_cfg_in = frames_cfg_ff;
      period_in     = period_ff;
      free_in       = free_ff;
      next_in       = next_ff;
      oldest_in     = oldest_ff;
      acc_in        = acc_ff;
      faults_in     = faults_ff;
      mapped_in     = mapped_ff;
      refd_in       = refd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      page_in      = page_ff;
      wr_in        = wr_ff;
      bad_in       = bad_ff;
      fault_in     = fault_ff;
      frame_in     = frame_ff;
      evict_in     = evict_ff;
      victim_in    = victim_ff;
      clear_ref_in = clear_ref_ff;
      use_free_in  = use_free_ff;
      need_div_in  = need_div_ff;
      row_in       = row_ff;
      grp_any_in   = grp_any_ff;
      grp_in       = grp_ff;
      mod_rem_in   = mod_rem_ff;
      mod_dvd_in   = mod_dvd_ff;
      mod_cnt_in   = mod_cnt_ff;

      rsp_fault_in   = rsp_fault_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_evicted_in = rsp_evicted_ff;
      rsp_victim_in  = rsp_victim_ff;
      rsp_bad_in     = rsp_bad_ff;
      rsp_total_in   = rsp_total_ff;

      pg_wr_en   = 1'b0;
      pg_wr_addr = page_ff;
      pg_new     = '0;
      pg_rd_en   = 1'b0;
      pg_rd_addr = req_ch.page_number;
      bm_wr_en   = 1'b0;
      bm_wr_addr = frame_ff;
      bm_wr_data = row_new;
      bm_rd_en   = 1'b0;
      bm_rd_addr = frame_sel;

      case (state_ff)
         // zero every frame row after reset
         ST_CLEAR: begin
            bm_wr_en    = 1'b1;
            bm_wr_addr  = clr_addr_ff;
            bm_wr_data  = '0;
            clr_addr_in = clr_addr_ff + fpr_pkg::FRAME_W'(1);
            if (clr_addr_ff == fpr_pkg::FRAME_W'(fpr_pkg::FRAME_ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // take a word and start the page table read for an in-range page
         ST_IDLE: begin
            if (req_ch.valid) begin
               page_in   = req_ch.page_number;
               wr_in     = req_ch.is_write;
               bad_in    = req_bad;
               fault_in  = 1'b0;
               frame_in  = '0;
               evict_in  = 1'b0;
               victim_in = '0;
               pg_rd_en  = !req_bad;
               state_in  = req_bad ? ST_DONE : ST_LOOK;
            end
         end

         // hit or miss, pick the frame on a miss
         ST_LOOK: begin
            acc_in       = clear_now ? '0 : acc_inc[fpr_pkg::PERIOD_W-1:0];
            clear_ref_in = clear_now;
            if (mapped_ff[page_ff]) begin
               refd_in[page_ff] = 1'b1;
               frame_in         = pg_entry.frame;
               state_in         = ST_DONE;
            end else begin
               fault_in    = 1'b1;
               use_free_in = (free_ff != '0);
               frame_in    = frame_sel;
               if (free_ff != '0) begin
                  free_in = free_ff - fpr_pkg::FRAME_W'(1);
               end
               bm_rd_en = 1'b1;
               state_in = ST_SCAN_LOAD;
            end
         end

         // latch the frame row and its group flags
         ST_SCAN_LOAD: begin
            row_in = bm_rd_data;
            for (int g = 0; g < fpr_pkg::NUM_GROUPS; g++) begin
               grp_any_in[g] = |bm_rd_data[g * fpr_pkg::GROUP_W +: fpr_pkg::GROUP_W];
            end
            state_in = use_free_ff ? ST_WRITE_MAP : ST_SCAN_GROUP;
         end

         // lowest group holding a mapped page
         ST_SCAN_GROUP: begin
            grp_in   = fpr_pkg::GROUP_IDX_W'(lowest_set(fpr_pkg::GROUP_W'(grp_any_ff)));
            evict_in = |grp_any_ff;
            state_in = ST_SCAN_BIT;
         end

         // lowest page within that group
         ST_SCAN_BIT: begin
            if (evict_ff) begin
               victim_in = fpr_pkg::PAGE_W'({grp_ff, lowest_set(grp_bits)});
            end
            state_in = ST_WRITE_MAP;
         end

         // write the new mapping and advance the pointer on the fast path
         ST_WRITE_MAP: begin
            bm_wr_en          = 1'b1;
            pg_wr_en          = 1'b1;
            pg_new.frame      = frame_ff;
            pg_new.dirty      = wr_ff;
            pg_new.last_write = wr_ff;
            mapped_in[page_ff] = 1'b1;
            refd_in[page_ff]   = 1'b1;
            if (evict_ff) begin
               mapped_in[victim_ff] = 1'b0;
               refd_in[victim_ff]   = 1'b0;
            end
            if (clear_ref_ff) begin
               refd_in = '0;
            end
            need_div_in = 1'b0;
            if (ptr_inc < {1'b0, eff}) begin
               if (use_free_ff) begin
                  next_in = ptr_inc[fpr_pkg::FRAME_W-1:0];
               end else begin
                  oldest_in = ptr_inc[fpr_pkg::FRAME_W-1:0];
               end
            end else if (ptr_inc == {1'b0, eff}) begin
               if (use_free_ff) begin
                  next_in = '0;
               end else begin
                  oldest_in = '0;
               end
            end else begin
               need_div_in = 1'b1;
               mod_rem_in  = '0;
               mod_dvd_in  = ptr_inc;
               mod_cnt_in  = '0;
            end
            if (evict_ff) begin
               state_in = ST_WRITE_VICTIM;
            end else if (ptr_inc > {1'b0, eff}) begin
               state_in = ST_NEXT_PTR;
            end else begin
               state_in = ST_DONE;
            end
         end

         // clear the evicted page's entry
         ST_WRITE_VICTIM: begin
            pg_wr_en   = 1'b1;
            pg_wr_addr = victim_ff;
            pg_new     = '0;
            state_in   = need_div_ff ? ST_NEXT_PTR : ST_DONE;
         end

         // restoring modulo, one bit per cycle
         ST_NEXT_PTR: begin
            mod_rem_in = div_try;
            if (div_try >= {1'b0, eff}) begin
               mod_rem_in = div_try - {1'b0, eff};
            end
            mod_dvd_in = {mod_dvd_ff[fpr_pkg::DIV_W-2:0], 1'b0};
            mod_cnt_in = mod_cnt_ff + fpr_pkg::DIV_CNT_W'(1);
            if (mod_cnt_ff == fpr_pkg::DIV_CNT_W'(fpr_pkg::DIV_W - 1)) begin
               if (use_free_ff) begin
                  next_in = mod_rem_in[fpr_pkg::FRAME_W-1:0];
               end else begin
                  oldest_in = mod_rem_in[fpr_pkg::FRAME_W-1:0];
               end
               state_in = ST_DONE;
            end
         end

         // hand the result to the output register
         ST_DONE: begin
            if (rsp_free) begin
               faults_in      = faults_ff + fpr_pkg::TOTAL_W'(fault_ff);
               rsp_valid_in   = 1'b1;
               rsp_fault_in   = fault_ff;
               rsp_frame_in   = frame_ff;
               rsp_evicted_in = evict_ff;
               rsp_victim_in  = victim_ff;
               rsp_bad_in     = bad_ff;
               rsp_total_in   = faults_ff + fpr_pkg::TOTAL_W'(fault_ff);
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // configuration writes
      if (csr_ch.valid) begin
         case (fpr_pkg::csr_index_type'(csr_ch.index))
            fpr_pkg::REG_PAGES_IN_USE: begin
               pages_cfg_in = csr_ch.data[fpr_pkg::PAGES_CFG_W-1:0];
            end
            fpr_pkg::REG_FRAMES_IN_USE: begin
               frames_cfg_in = csr_ch.data[fpr_pkg::FRAMES_CFG_W-1:0];
               free_in       = eff_frames(csr_ch.data[fpr_pkg::FRAMES_CFG_W-1:0]);
            end
            fpr_pkg::REG_CLEAR_PERIOD: begin
               period_in = csr_ch.data[fpr_pkg::PERIOD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign pg_wr_data = pg_new;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         pages_cfg_ff  <= fpr_pkg::PAGES_CFG_W'(256);
         frames_cfg_ff <= fpr_pkg::FRAMES_CFG_W'(64);
         period_ff     <= fpr_pkg::PERIOD_W'(1);
         free_ff       <= eff_frames(fpr_pkg::FRAME_W'(64));
         next_ff       <= '0;
         oldest_ff     <= '0;
         acc_ff        <= '0;
         faults_ff     <= '0;
         mapped_ff     <= '0;
         refd_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         pages_cfg_ff  <= pages_cfg_in;
         frames_cfg_ff <= frames_cfg_in;
         period_ff     <= period_in;
         free_ff       <= free_in;
         next_ff       <= next_in;
         oldest_ff     <= oldest_in;
         acc_ff        <= acc_in;
         faults_ff     <= faults_in;
         mapped_ff     <= mapped_in;
         refd_ff       <= refd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      page_ff        <= page_in;
      wr_ff          <= wr_in;
      bad_ff         <= bad_in;
      fault_ff       <= fault_in;
      frame_ff       <= frame_in;
      evict_ff       <= evict_in;
      victim_ff      <= victim_in;
      clear_ref_ff   <= clear_ref_in;
      use_free_ff    <= use_free_in;
      need_div_ff    <= need_div_in;
      row_ff         <= row_in;
      grp_any_ff     <= grp_any_in;
      grp_ff         <= grp_in;
      mod_rem_ff     <= mod_rem_in;
      mod_dvd_ff     <= mod_dvd_in;
      mod_cnt_ff     <= mod_cnt_in;
      rsp_fault_ff   <= rsp_fault_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_evicted_ff <= rsp_evicted_in;
      rsp_victim_ff  <= rsp_victim_in;
      rsp_bad_ff     <= rsp_bad_in;
      rsp_total_ff   <= rsp_total_in;
   end

   // checks
   a_look_after_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK) |-> $past(req_ch.valid && req_ch.ready))
      else $error("page lookup without an accepted word");

   a_pointers_in_range: assert property (@(posedge clock) disable iff (reset)
      (next_ff < fpr_pkg::FRAME_W'(fpr_pkg::MAX_FRAMES)) &&
      (oldest_ff < fpr_pkg::FRAME_W'(fpr_pkg::MAX_FRAMES)))
      else $error("frame pointer beyond the frame limit");

   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      free_ff <= eff)
      else $error("free frame count above the frame count");

endmodule

`default_nettype wire
